// ===== src/dget_pkg.sv =====
// Shared constants, request/result types and codes for the graph edit table.
`default_nettype none

package dget_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int ROW_W     = 16;

    typedef logic [ROW_W-1:0] row_t;

    typedef enum logic [2:0] {
        ACT_CREATE = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_APPEND = 3'd3,
        ACT_DELETE = 3'd4,
        ACT_READ   = 3'd5,
        ACT_CLEAR  = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOGRAPH = 3'd1,
        ST_SELF    = 3'd2,
        ST_BAD     = 3'd3,
        ST_DUP     = 3'd4,
        ST_ABSENT  = 3'd5,
        ST_FULL    = 3'd6
    } status_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [NODE_W-1:0]  node;
        logic [NODE_W-1:0]  neighbor;
        logic [COUNT_W-1:0] size;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [ROW_W-1:0]   neighbors;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;
    } dget_cmd_t;

endpackage

`default_nettype wire

// ===== src/dget_ctrl.sv =====
// Handshake controller: decides when a request executes and when a result is held.
`default_nettype none

module dget_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dget_pkg::dget_cmd_t    cmd
);
    import dget_pkg::*;

    typedef enum logic [1:0] {
        CTL_EMPTY = 2'b01,
        CTL_HELD  = 2'b10
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    logic       accept;

    // a held result that is being taken frees the register for the next request
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            CTL_EMPTY: in_ready = 1'b1;
            CTL_HELD:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default: in_ready = 1'b0;
        endcase
    end

    assign accept   = in_valid && in_ready;
    assign cmd.exec = accept;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_EMPTY:
            begin
                if (accept)
                    state_next = CTL_HELD;
            end
            CTL_HELD:
            begin
                if (out_ready && !accept)
                    state_next = CTL_EMPTY;
            end
            default: state_next = CTL_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CTL_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== src/dget_dpath.sv =====
// Datapath: adjacency matrix, node count, graph flag, edit logic and result register.
`default_nettype none

module dget_dpath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dget_pkg::dget_cmd_t cmd,
    input  wire dget_pkg::req_t      req,
    output dget_pkg::rsp_t           rsp
);
    import dget_pkg::*;

    row_t               adj_reg  [MAX_NODES];
    row_t               adj_next [MAX_NODES];
    row_t               shifted  [MAX_NODES];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               present_reg, present_next;
    rsp_t               rsp_reg, rsp_next;

    logic               node_ok, nb_ok, bit_set;
    logic [2:0]         status;
    row_t               row_out;

    // drop column k: bits below k stay, bits above move down by one
    function automatic row_t drop_col(input row_t row, input logic [NODE_W-1:0] k);
        row_t below;
        below = (row_t'(1) << k) - row_t'(1);
        return (row & below) | ((row >> ({1'b0, k} + COUNT_W'(1))) << k);
    endfunction

    assign node_ok = {1'b0, req.node} < count_reg;
    assign nb_ok   = {1'b0, req.neighbor} < count_reg;
    assign bit_set = adj_reg[req.node][req.neighbor];

    // rows one place up; rows at and above the count are always zero
    always_comb
    begin
        for (int r = 0; r < MAX_NODES - 1; r++)
            shifted[r] = adj_reg[r + 1];
        shifted[MAX_NODES-1] = '0;
    end

    always_comb
    begin
        status       = ST_OK;
        row_out      = '0;
        adj_next     = adj_reg;
        count_next   = count_reg;
        present_next = present_reg;
        case (req.action)
            ACT_CREATE:
            begin
                if (req.size > COUNT_W'(MAX_NODES))
                    status = ST_FULL;
                else
                begin
                    for (int r = 0; r < MAX_NODES; r++)
                        adj_next[r] = '0;
                    count_next   = req.size;
                    present_next = 1'b1;
                end
            end
            ACT_ADD:
            begin
                if (!present_reg)
                    status = ST_NOGRAPH;
                else if (req.node == req.neighbor)
                    status = ST_SELF;
                else if (!node_ok || !nb_ok)
                    status = ST_BAD;
                else if (bit_set)
                    status = ST_DUP;
                else
                    adj_next[req.node][req.neighbor] = 1'b1;
            end
            ACT_REMOVE:
            begin
                if (!present_reg)
                    status = ST_NOGRAPH;
                else if (!node_ok || !nb_ok)
                    status = ST_BAD;
                else if (!bit_set)
                    status = ST_ABSENT;
                else
                    adj_next[req.node][req.neighbor] = 1'b0;
            end
            ACT_APPEND:
            begin
                if (!present_reg)
                    status = ST_NOGRAPH;
                else if (count_reg >= COUNT_W'(MAX_NODES))
                    status = ST_FULL;
                else
                    count_next = count_reg + COUNT_W'(1);
            end
            ACT_DELETE:
            begin
                if (!present_reg)
                    status = ST_NOGRAPH;
                else if (!node_ok)
                    status = ST_BAD;
                else
                begin
                    for (int r = 0; r < MAX_NODES; r++)
                    begin
                        if (NODE_W'(r) < req.node)
                            adj_next[r] = drop_col(adj_reg[r], req.node);
                        else
                            adj_next[r] = drop_col(shifted[r], req.node);
                    end
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            ACT_READ:
            begin
                if (!present_reg)
                    status = ST_NOGRAPH;
                else if (!node_ok)
                    status = ST_BAD;
                else
                    row_out = adj_reg[req.node];
            end
            ACT_CLEAR:
            begin
                if (!present_reg)
                    status = ST_NOGRAPH;
                else
                begin
                    for (int r = 0; r < MAX_NODES; r++)
                        adj_next[r] = '0;
                    count_next   = '0;
                    present_next = 1'b0;
                end
            end
            default: status = ST_BAD;
        endcase
    end

    always_comb
    begin
        rsp_next.status    = status;
        rsp_next.neighbors = row_out;
        rsp_next.count     = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_NODES; r++)
                adj_reg[r] <= '0;
            count_reg   <= '0;
            present_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            adj_reg     <= adj_next;
            count_reg   <= count_next;
            present_reg <= present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== src/directed_graph_edit_table_unit.sv =====
// Top level of the directed graph edit table.
//
// Requests arrive on in_valid/in_ready/in_data: an action (create, add edge,
// remove edge, append node, delete node, read row, clear) with node, neighbor
// and size operands. Each request gives exactly one result on
// out_valid/out_ready/out_data: status, the row read (zero otherwise) and the
// node count after the action.
// Latency: the result is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken; the whole edit,
// including row and column removal on delete, is combinational on the flip-flop matrix.
// The single result register holds one result; while it is held and the
// receiver stalls (out_ready low), in_ready is low and the result and the
// graph stay unchanged. When the result is taken, a new request may be
// accepted in the same cycle.
// Reset (rst_n low, asynchronous) clears the matrix, the node count and the
// graph flag and empties the result register; actions other than create then
// answer no graph.
`default_nettype none

module directed_graph_edit_table_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire dget_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output dget_pkg::rsp_t      out_data
);
    import dget_pkg::*;

    dget_cmd_t cmd;

    dget_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    dget_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (in_data),
        .rsp   (out_data)
    );

endmodule

`default_nettype wire

// ===== src/dget_checker.sv =====
// Port-level checker for the graph edit table, bound to the top level.
`default_nettype none

module dget_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire dget_pkg::req_t in_data,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire dget_pkg::rsp_t out_data
);
    import dget_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("held result changed");

    // every accepted request gives a result next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request without result");

    // count never exceeds the table size
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.count <= COUNT_W'(MAX_NODES))
        else $error("node count beyond table size");

    // only a successful read returns a row
    a_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.neighbors == '0)
        else $error("row returned on failed request");

    // with no graph the count is zero
    a_nograph_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_NOGRAPH |-> out_data.count == '0)
        else $error("no graph but count nonzero");

endmodule

bind directed_graph_edit_table_unit dget_checker u_dget_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
